>>> design/cle_pkg.sv
// Shared types, sizes and operation codes of the cursor list engine.
package cle_pkg;

	localparam int CAPACITY    = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int LEN_W       = $clog2(CAPACITY + 1);
	localparam int IDX_W       = $clog2(CAPACITY);

	typedef enum logic [3:0] {
		OP_CLEAR     = 4'd0,
		OP_INSERT    = 4'd1,
		OP_REMOVE    = 4'd2,
		OP_VAL_FWD   = 4'd3,
		OP_VAL_BACK  = 4'd4,
		OP_CUR_FWD   = 4'd5,
		OP_CUR_BACK  = 4'd6,
		OP_READ      = 4'd7,
		OP_WRITE     = 4'd8,
		OP_CONTAINS  = 4'd9
	} op_t;

	// Broadcast to every cell; enables already carry the accept and boundary checks.
	typedef struct packed {
		logic                   ins;
		logic                   rem;
		logic                   fwd;
		logic                   back;
		logic                   wr;
		logic [LEN_W-1:0]       pos;
		logic [LEN_W-1:0]       cur;
		logic [LEN_W-1:0]       len;
		logic [VALUE_WIDTH-1:0] val;
	} cle_ctrl_t;

endpackage

>>> design/cle_req_if.sv
// Request channel: one operation word per handshake.
interface cle_req_if;
	logic        valid;
	logic        ready;
	logic [3:0]  operation;
	logic [31:0] value;

	modport source (output valid, output operation, output value, input ready);
	modport sink   (input valid, input operation, input value, output ready);
endinterface

>>> design/cle_rsp_if.sv
// Response channel: one result word per handshake.
interface cle_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_value;
	logic        done_res;
	logic        found;
	logic [6:0]  length;
	logic [6:0]  cursor;

	modport source (output valid, output read_value, output done_res, output found,
		output length, output cursor, input ready);
	modport sink   (input valid, input read_value, input done_res, input found,
		input length, input cursor, output ready);
endinterface

>>> design/cle_cell.sv
// One list slot: holds an entry and takes its next value from itself, a neighbour or the input.
module cle_cell
	import cle_pkg::*;
(
	input  logic                   clk,
	input  logic [IDX_W-1:0]       idx,
	input  cle_ctrl_t              ctrl,
	input  logic [VALUE_WIDTH-1:0] left,
	input  logic [VALUE_WIDTH-1:0] right,
	output logic [VALUE_WIDTH-1:0] entry,
	output logic                   match,
	output logic [VALUE_WIDTH-1:0] rd_part
);

	logic [VALUE_WIDTH-1:0] entry_q;
	logic [LEN_W-1:0]       k;
	logic [LEN_W-1:0]       k_inc;
	logic [LEN_W-1:0]       cur_inc;
	logic                   take_val;
	logic                   take_left;
	logic                   take_right;

	assign k       = LEN_W'(idx);
	assign k_inc   = k + LEN_W'(1);
	assign cur_inc = ctrl.cur + LEN_W'(1);

	assign take_val   = (ctrl.ins && k == ctrl.pos) || (ctrl.wr && k == ctrl.cur);
	assign take_left  = (ctrl.ins && k > ctrl.pos && k <= ctrl.len)
		|| (ctrl.fwd && k == cur_inc) || (ctrl.back && k == ctrl.cur);
	assign take_right = (ctrl.rem && k >= ctrl.cur && k_inc < ctrl.len)
		|| (ctrl.fwd && k == ctrl.cur) || (ctrl.back && k_inc == ctrl.cur);

	always_ff @(posedge clk) begin
		if (take_val) begin
			entry_q <= ctrl.val;
		end else if (take_left) begin
			entry_q <= left;
		end else if (take_right) begin
			entry_q <= right;
		end
	end

	assign entry   = entry_q;
	assign match   = (entry_q == ctrl.val) && (k < ctrl.len);
	assign rd_part = (k == ctrl.cur) ? entry_q : '0;

endmodule

>>> design/cursor_list_engine_top.sv
// Top level of the cursor list engine: control, cell row and result register.
// Usage:
//   The request channel (req) carries one operation word: an operation code and a
//   value. The response channel (rsp) returns one result word per request: the
//   value read, whether the operation took effect, the membership flag and the
//   new length and cursor.
//   The list lives in a row of 64 cells, one entry each. Inserts and removes
//   shift every later entry by one place, each cell taking its neighbour's entry;
//   membership is compared in every cell at once.
//   Result: registered, it appears in the cycle after the request is accepted.
//   Throughput: one operation per cycle while rsp.ready is high; the single result register sets it.
//   Stall: while a result waits and rsp.ready is low, req.ready is low too;
//   the waiting result and the list state hold. A request is taken in the same
//   cycle that the waiting result is taken.
//   Reset: arst_n clears the length, the cursor and the result valid. Entries
//   are not cleared; no operation reads an entry outside the list.
module cursor_list_engine_top
	import cle_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	cle_req_if.sink   req,
	cle_rsp_if.source rsp
);

	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] cur_q;

	logic                   rsp_valid_q;
	logic [VALUE_WIDTH-1:0] read_value_q;
	logic                   done_q;
	logic                   found_q;
	logic [LEN_W-1:0]       length_q;
	logic [LEN_W-1:0]       cursor_q;

	logic                   accept;
	op_t                    op;
	logic                   in_list;
	logic                   has_next;
	logic [LEN_W-1:0]       cur_inc;
	logic [LEN_W-1:0]       ins_pos;
	logic                   done;
	logic                   found;
	logic [LEN_W-1:0]       len_n;
	logic [LEN_W-1:0]       cur_n;
	logic [VALUE_WIDTH-1:0] rd_val;
	logic [VALUE_WIDTH-1:0] rd_sel;
	cle_ctrl_t              ctrl;

	logic [VALUE_WIDTH-1:0] entry_v   [CAPACITY];
	logic [VALUE_WIDTH-1:0] rd_part_v [CAPACITY];
	logic [CAPACITY-1:0]    match_v;

	// Take a new word whenever the result register is free or is emptied now.
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign op        = op_t'(req.operation);

	assign in_list  = cur_q < len_q;
	assign cur_inc  = cur_q + LEN_W'(1);
	assign has_next = cur_inc < len_q;
	// Insert after the cursor; at the front when empty, at the end when past it.
	assign ins_pos  = (len_q == '0) ? '0 : ((cur_inc > len_q) ? len_q : cur_inc);

	// Gather the entry under the cursor from the one cell that drives it.
	always_comb begin
		rd_sel = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_sel = rd_sel | rd_part_v[i];
		end
	end

	always_comb begin
		done   = 1'b0;
		found  = 1'b0;
		rd_val = '0;
		len_n  = len_q;
		cur_n  = cur_q;
		case (op)
			OP_CLEAR: begin
				done  = 1'b1;
				len_n = '0;
				cur_n = '0;
			end
			OP_INSERT: begin
				if (len_q < LEN_W'(CAPACITY)) begin
					done  = 1'b1;
					len_n = len_q + LEN_W'(1);
				end
			end
			OP_REMOVE: begin
				if (in_list) begin
					done  = 1'b1;
					len_n = len_q - LEN_W'(1);
				end
			end
			OP_VAL_FWD: begin
				done = has_next;
			end
			OP_VAL_BACK: begin
				done = (cur_q != '0) && in_list;
			end
			OP_CUR_FWD: begin
				if (has_next) begin
					done  = 1'b1;
					cur_n = cur_inc;
				end
			end
			OP_CUR_BACK: begin
				if (cur_q != '0) begin
					done  = 1'b1;
					cur_n = cur_q - LEN_W'(1);
				end
			end
			OP_READ: begin
				if (in_list) begin
					done   = 1'b1;
					rd_val = rd_sel;
				end
			end
			OP_WRITE: begin
				done = in_list;
			end
			OP_CONTAINS: begin
				done  = 1'b1;
				found = |match_v;
			end
			default: begin
				done = 1'b0;
			end
		endcase
	end

	// Broadcast to the row; the enables move entries only on an accepted word.
	always_comb begin
		ctrl.ins  = accept && (op == OP_INSERT) && done;
		ctrl.rem  = accept && (op == OP_REMOVE) && done;
		ctrl.fwd  = accept && (op == OP_VAL_FWD) && done;
		ctrl.back = accept && (op == OP_VAL_BACK) && done;
		ctrl.wr   = accept && (op == OP_WRITE) && done;
		ctrl.pos  = ins_pos;
		ctrl.cur  = cur_q;
		ctrl.len  = len_q;
		ctrl.val  = req.value;
	end

	// Row of cells; each sees its left and right neighbour, the ends see zero.
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic [VALUE_WIDTH-1:0] left_val;
		logic [VALUE_WIDTH-1:0] right_val;

		if (k == 0) begin : g_first
			assign left_val = '0;
		end else begin : g_mid_l
			assign left_val = entry_v[k-1];
		end
		if (k == CAPACITY - 1) begin : g_last
			assign right_val = '0;
		end else begin : g_mid_r
			assign right_val = entry_v[k+1];
		end

		cle_cell u_cell (
			.clk     (clk),
			.idx     (IDX_W'(k)),
			.ctrl    (ctrl),
			.left    (left_val),
			.right   (right_val),
			.entry   (entry_v[k]),
			.match   (match_v[k]),
			.rd_part (rd_part_v[k])
		);
	end

	// List length and cursor: advance only on an accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			cur_q <= '0;
		end else if (accept) begin
			len_q <= len_n;
			cur_q <= cur_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Result payload: load on accept, hold while the receiver stalls.
	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q <= rd_val;
			done_q       <= done;
			found_q      <= found;
			length_q     <= len_n;
			cursor_q     <= cur_n;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = read_value_q;
	assign rsp.done_res   = done_q;
	assign rsp.found      = found_q;
	assign rsp.length     = length_q;
	assign rsp.cursor     = cursor_q;

endmodule
